FILE: src/ttf_pkg.sv
// Package with the widths, types and state encodings of the tangent frame block.
`timescale 1ns / 1ps
package ttf_pkg;

  // Input coordinate width and output fraction bits.
  localparam int CW    = 32;
  localparam int OF    = 14;
  localparam int OUT_W = 16;

  // Derived datapath widths.
  localparam int DW    = CW + 1;           // edge and uv delta
  localparam int PW    = 2 * DW;           // one product of two deltas
  localparam int VW    = PW + 2;           // difference of two products, then negated
  localparam int MW    = VW - 1;           // magnitude of a vector component
  localparam int NW    = 31;               // left-aligned magnitude kept for normalizing
  localparam int SW    = 2 * NW + 2;       // sum of three squares
  localparam int RW    = NW + 1;           // square root of the sum
  localparam int QW    = OF + 1;           // unit component magnitude
  localparam int QXW   = (QW > OUT_W) ? QW : OUT_W;
  localparam int ND    = NW + OF + 1;      // division numerator
  localparam int CNTW  = $clog2(RW + 1);
  localparam int NSTEP = 14;               // products per triangle
  localparam int KW    = $clog2(NSTEP);
  localparam int NRES  = NSTEP / 2;
  localparam int RESW  = $clog2(NRES);
  localparam int QDEPTH = 2;
  localparam int PTRW  = $clog2(QDEPTH);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;
  typedef logic [2:0][VW-1:0]   vec_t;
  typedef logic [OUT_W-1:0]     unit_t;

  typedef struct packed {
    delta_t e1_x;
    delta_t e1_y;
    delta_t e1_z;
    delta_t e2_x;
    delta_t e2_y;
    delta_t e2_z;
    delta_t du1;
    delta_t dv1;
    delta_t du2;
    delta_t dv2;
  } tri_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_NSTART,
    B_NWAIT,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_ALIGN,
    N_SQ,
    N_SQRT,
    N_DLOAD,
    N_DIV,
    N_DONE
  } norm_state_t;

endpackage

FILE: src/ttf_if.sv
// Valid/ready channel interfaces for vertices in and tangent frames out.
`timescale 1ns / 1ps
interface ttf_vtx_if;
  logic            valid;
  logic            ready;
  ttf_pkg::coord_t pos_x;
  ttf_pkg::coord_t pos_y;
  ttf_pkg::coord_t pos_z;
  ttf_pkg::coord_t tex_u;
  ttf_pkg::coord_t tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
  modport monitor (input valid, ready, pos_x, pos_y, pos_z, tex_u, tex_v);
endinterface

interface ttf_frame_if;
  logic           valid;
  logic           ready;
  ttf_pkg::unit_t tangent_x;
  ttf_pkg::unit_t tangent_y;
  ttf_pkg::unit_t tangent_z;
  ttf_pkg::unit_t bitangent_x;
  ttf_pkg::unit_t bitangent_y;
  ttf_pkg::unit_t bitangent_z;
  logic           degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, output ready);
  modport monitor (input valid, ready, tangent_x, tangent_y, tangent_z, bitangent_x,
                   bitangent_y, bitangent_z, degenerate);
endinterface

FILE: src/ttf_front.sv
// Front end: collects vertices and forms the edges and uv deltas of each triangle.
`timescale 1ns / 1ps
module ttf_front (
  input  logic          clk,
  input  logic          rst,
  ttf_vtx_if.sink       vtx,
  input  logic          q_full,
  output logic          q_push,
  output ttf_pkg::tri_t q_data
);

  logic [1:0]      count;
  ttf_pkg::coord_t v0 [5];
  ttf_pkg::coord_t v1 [5];
  logic            accept;
  logic            third;

  function automatic ttf_pkg::delta_t dsub(ttf_pkg::coord_t a, ttf_pkg::coord_t b);
    ttf_pkg::delta_t ae;
    ttf_pkg::delta_t be;
    ae = ttf_pkg::delta_t'(a);
    be = ttf_pkg::delta_t'(b);
    return ae - be;
  endfunction

  assign third     = (count >= 2'd2);
  assign vtx.ready = !third || !q_full;
  assign accept    = vtx.valid && vtx.ready;
  assign q_push    = accept && third;

  always_comb begin
    q_data.e1_x = dsub(v1[0], v0[0]);
    q_data.e1_y = dsub(v1[1], v0[1]);
    q_data.e1_z = dsub(v1[2], v0[2]);
    q_data.e2_x = dsub(vtx.pos_x, v0[0]);
    q_data.e2_y = dsub(vtx.pos_y, v0[1]);
    q_data.e2_z = dsub(vtx.pos_z, v0[2]);
    q_data.du1  = dsub(v1[3], v0[3]);
    q_data.dv1  = dsub(v1[4], v0[4]);
    q_data.du2  = dsub(vtx.tex_u, v0[3]);
    q_data.dv2  = dsub(vtx.tex_v, v0[4]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= third ? 2'd0 : count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count == 2'd0) begin
      v0[0] <= vtx.pos_x;
      v0[1] <= vtx.pos_y;
      v0[2] <= vtx.pos_z;
      v0[3] <= vtx.tex_u;
      v0[4] <= vtx.tex_v;
    end
    if (accept && count == 2'd1) begin
      v1[0] <= vtx.pos_x;
      v1[1] <= vtx.pos_y;
      v1[2] <= vtx.pos_z;
      v1[3] <= vtx.tex_u;
      v1[4] <= vtx.tex_v;
    end
  end

endmodule

FILE: src/ttf_queue.sv
// Short triangle queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module ttf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttf_pkg::tri_t push_data,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output ttf_pkg::tri_t pop_data
);

  ttf_pkg::tri_t               entry [ttf_pkg::QDEPTH];
  logic [ttf_pkg::PTRW-1:0]    wp;
  logic [ttf_pkg::PTRW-1:0]    rp;
  logic [ttf_pkg::PTRW:0]      fill;
  logic                        do_push;
  logic                        do_pop;

  assign full     = (fill == (ttf_pkg::PTRW + 1)'(ttf_pkg::QDEPTH));
  assign valid    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == ttf_pkg::PTRW'(ttf_pkg::QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == ttf_pkg::PTRW'(ttf_pkg::QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= push_data;
    end
  end

endmodule

FILE: src/ttf_norm.sv
// Iterative vector normalizer: align, sum of squares, bitwise square root, division.
`timescale 1ns / 1ps
module ttf_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ttf_pkg::vec_t        vec,
  output logic                 done,
  output logic                 zero,
  output ttf_pkg::unit_t [2:0] q
);

  ttf_pkg::norm_state_t        state;
  ttf_pkg::norm_state_t        state_next;
  logic [ttf_pkg::MW-1:0]      mag [3];
  logic                        neg [3];
  logic [1:0]                  idx;
  logic                        phase;
  logic [ttf_pkg::CNTW-1:0]    cnt;
  logic [ttf_pkg::SW-1:0]      s;
  logic [ttf_pkg::SW-1:0]      sq;
  logic [ttf_pkg::SW-1:0]      sv;
  logic [ttf_pkg::RW+1:0]      rem_s;
  logic [ttf_pkg::RW-1:0]      root;
  logic [ttf_pkg::RW-1:0]      drem;
  logic [ttf_pkg::QW-1:0]      dlow;

  logic [ttf_pkg::MW-1:0]      orv;
  logic [ttf_pkg::NW-1:0]      m_sel;
  logic [2*ttf_pkg::NW-1:0]    m_sq;
  logic [ttf_pkg::VW-1:0]      absv [3];
  logic [ttf_pkg::SW-1:0]      s_sum;
  logic [ttf_pkg::RW+3:0]      rem2;
  logic [ttf_pkg::RW+3:0]      trial;
  logic [ttf_pkg::RW+3:0]      rem_sub;
  logic                        sq_ge;
  logic [ttf_pkg::ND-1:0]      num;
  logic [ttf_pkg::RW:0]        dr2;
  logic                        d_ge;
  logic [ttf_pkg::QW-1:0]      dlow_new;
  logic [ttf_pkg::QXW-1:0]     qx;
  logic [ttf_pkg::QXW-1:0]     qs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i] = vec[i][ttf_pkg::VW-1] ? (~vec[i] + 1'b1) : vec[i];
    end
  end

  assign orv   = mag[0] | mag[1] | mag[2];
  assign m_sel = mag[idx][ttf_pkg::MW-1 -: ttf_pkg::NW];
  assign m_sq  = m_sel * m_sel;
  assign s_sum = s + sq;

  // One result bit of the square root per cycle.
  assign rem2    = {rem_s, sv[ttf_pkg::SW-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign rem_sub = rem2 - trial;
  assign sq_ge   = (rem2 >= trial);

  // Rounded quotient: the numerator carries half of the root.
  assign num = ttf_pkg::ND'({m_sel, {ttf_pkg::OF{1'b0}}}) + ttf_pkg::ND'(root >> 1);
  assign dr2 = {drem, dlow[ttf_pkg::QW-1]};
  assign d_ge = (dr2 >= {1'b0, root});
  assign dlow_new = {dlow[ttf_pkg::QW-2:0], d_ge};
  assign qx = ttf_pkg::QXW'(dlow_new);
  assign qs = neg[idx] ? (~qx + 1'b1) : qx;

  always_comb begin
    state_next = state;
    case (state)
      ttf_pkg::N_IDLE: begin
        if (start) state_next = ttf_pkg::N_ALIGN;
      end
      ttf_pkg::N_ALIGN: begin
        if (orv == '0) begin
          state_next = ttf_pkg::N_DONE;
        end else if (orv[ttf_pkg::MW-1]) begin
          state_next = ttf_pkg::N_SQ;
        end
      end
      ttf_pkg::N_SQ: begin
        if (phase && idx == 2'd2) state_next = ttf_pkg::N_SQRT;
      end
      ttf_pkg::N_SQRT: begin
        if (cnt == ttf_pkg::CNTW'(ttf_pkg::RW - 1)) state_next = ttf_pkg::N_DLOAD;
      end
      ttf_pkg::N_DLOAD: begin
        state_next = ttf_pkg::N_DIV;
      end
      ttf_pkg::N_DIV: begin
        if (cnt == ttf_pkg::CNTW'(ttf_pkg::QW - 1)) begin
          state_next = (idx == 2'd2) ? ttf_pkg::N_DONE : ttf_pkg::N_DLOAD;
        end
      end
      ttf_pkg::N_DONE: begin
        state_next = ttf_pkg::N_IDLE;
      end
      default: begin
        state_next = ttf_pkg::N_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state)
      ttf_pkg::N_DONE: done = 1'b1;
      default:         done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttf_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ttf_pkg::N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][ttf_pkg::VW-1];
            mag[i] <= absv[i][ttf_pkg::MW-1:0];
          end
          q     <= '0;
          zero  <= 1'b0;
          idx   <= 2'd0;
          phase <= 1'b0;
          s     <= '0;
        end
      end
      ttf_pkg::N_ALIGN: begin
        if (orv == '0) begin
          zero <= 1'b1;
        end else if (!orv[ttf_pkg::MW-1]) begin
          // Coarse steps first while the top nibble is empty.
          for (int i = 0; i < 3; i++) begin
            if (orv[ttf_pkg::MW-1 -: 4] == 4'd0) begin
              mag[i] <= mag[i] << 4;
            end else begin
              mag[i] <= mag[i] << 1;
            end
          end
        end
      end
      ttf_pkg::N_SQ: begin
        if (!phase) begin
          sq    <= ttf_pkg::SW'(m_sq);
          phase <= 1'b1;
        end else begin
          s     <= s_sum;
          phase <= 1'b0;
          if (idx == 2'd2) begin
            idx   <= 2'd0;
            cnt   <= '0;
            sv    <= s_sum;
            rem_s <= '0;
            root  <= '0;
          end else begin
            idx <= idx + 2'd1;
          end
        end
      end
      ttf_pkg::N_SQRT: begin
        rem_s <= sq_ge ? rem_sub[ttf_pkg::RW+1:0] : rem2[ttf_pkg::RW+1:0];
        root  <= {root[ttf_pkg::RW-2:0], sq_ge};
        sv    <= sv << 2;
        cnt   <= cnt + 1'b1;
      end
      ttf_pkg::N_DLOAD: begin
        drem <= ttf_pkg::RW'(num[ttf_pkg::ND-1:ttf_pkg::QW]);
        dlow <= num[ttf_pkg::QW-1:0];
        cnt  <= '0;
      end
      ttf_pkg::N_DIV: begin
        drem <= d_ge ? ttf_pkg::RW'(dr2 - {1'b0, root}) : dr2[ttf_pkg::RW-1:0];
        dlow <= dlow_new;
        cnt  <= cnt + 1'b1;
        if (cnt == ttf_pkg::CNTW'(ttf_pkg::QW - 1)) begin
          q[idx] <= qs[ttf_pkg::OUT_W-1:0];
          idx    <= idx + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/ttf_back.sv
// Back end: determinant and frame products on one shared multiplier, then normalizing.
`timescale 1ns / 1ps
module ttf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ttf_pkg::tri_t q_data,
  output logic          q_pop,
  ttf_frame_if.source   frame
);

  ttf_pkg::back_state_t        state;
  ttf_pkg::back_state_t        state_next;
  ttf_pkg::tri_t               tri_r;
  logic [ttf_pkg::KW-1:0]      k;
  logic signed [ttf_pkg::PW-1:0] prod;
  logic signed [ttf_pkg::VW-1:0] acc;
  logic signed [ttf_pkg::VW-1:0] res [ttf_pkg::NRES];
  logic                        vi;
  logic                        ok_t;
  ttf_pkg::unit_t [2:0]        t_hold;
  ttf_pkg::unit_t [2:0]        b_hold;
  logic                        degen_hold;
  logic                        fval;

  ttf_pkg::delta_t             op_a;
  ttf_pkg::delta_t             op_b;
  logic signed [ttf_pkg::PW-1:0] mul_w;
  logic signed [ttf_pkg::VW-1:0] prod_x;
  logic signed [ttf_pkg::VW-1:0] diff;
  logic                        last_step;
  logic                        det_zero;
  logic                        det_neg;
  ttf_pkg::vec_t               nvec;
  logic                        n_start;
  logic                        n_done;
  logic                        n_zero;
  ttf_pkg::unit_t [2:0]        n_q;
  logic                        load_out;

  // Even steps load the first product of a pair, odd steps subtract the second.
  always_comb begin
    case (k)
      4'd0:    begin op_a = tri_r.du1; op_b = tri_r.dv2;  end
      4'd1:    begin op_a = tri_r.du2; op_b = tri_r.dv1;  end
      4'd2:    begin op_a = tri_r.dv2; op_b = tri_r.e1_x; end
      4'd3:    begin op_a = tri_r.dv1; op_b = tri_r.e2_x; end
      4'd4:    begin op_a = tri_r.du1; op_b = tri_r.e2_x; end
      4'd5:    begin op_a = tri_r.du2; op_b = tri_r.e1_x; end
      4'd6:    begin op_a = tri_r.dv2; op_b = tri_r.e1_y; end
      4'd7:    begin op_a = tri_r.dv1; op_b = tri_r.e2_y; end
      4'd8:    begin op_a = tri_r.du1; op_b = tri_r.e2_y; end
      4'd9:    begin op_a = tri_r.du2; op_b = tri_r.e1_y; end
      4'd10:   begin op_a = tri_r.dv2; op_b = tri_r.e1_z; end
      4'd11:   begin op_a = tri_r.dv1; op_b = tri_r.e2_z; end
      4'd12:   begin op_a = tri_r.du1; op_b = tri_r.e2_z; end
      4'd13:   begin op_a = tri_r.du2; op_b = tri_r.e1_z; end
      default: begin op_a = '0;        op_b = '0;        end
    endcase
  end

  assign mul_w     = op_a * op_b;
  assign prod_x    = ttf_pkg::VW'(prod);
  assign diff      = acc - prod_x;
  assign last_step = (k == ttf_pkg::KW'(ttf_pkg::NSTEP - 1));
  assign det_zero  = (res[0] == '0);
  assign det_neg   = res[0][ttf_pkg::VW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvec[i] = vi ? res[2 + 2 * i] : res[1 + 2 * i];
      if (det_neg) begin
        nvec[i] = ~nvec[i] + 1'b1;
      end
    end
  end

  ttf_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .vec   (nvec),
    .done  (n_done),
    .zero  (n_zero),
    .q     (n_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ttf_pkg::B_IDLE: begin
        if (q_valid) state_next = ttf_pkg::B_MUL;
      end
      ttf_pkg::B_MUL: begin
        state_next = ttf_pkg::B_ACC;
      end
      ttf_pkg::B_ACC: begin
        if (!last_step) begin
          state_next = ttf_pkg::B_MUL;
        end else begin
          state_next = det_zero ? ttf_pkg::B_OUT : ttf_pkg::B_NSTART;
        end
      end
      ttf_pkg::B_NSTART: begin
        state_next = ttf_pkg::B_NWAIT;
      end
      ttf_pkg::B_NWAIT: begin
        if (n_done) state_next = vi ? ttf_pkg::B_OUT : ttf_pkg::B_NSTART;
      end
      ttf_pkg::B_OUT: begin
        if (!fval || frame.ready) state_next = ttf_pkg::B_IDLE;
      end
      default: begin
        state_next = ttf_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    n_start  = 1'b0;
    load_out = 1'b0;
    case (state)
      ttf_pkg::B_IDLE:   q_pop    = q_valid;
      ttf_pkg::B_NSTART: n_start  = 1'b1;
      ttf_pkg::B_OUT:    load_out = !fval || frame.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttf_pkg::B_IDLE;
      fval  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        fval <= 1'b1;
      end else if (frame.ready) begin
        fval <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ttf_pkg::B_IDLE: begin
        if (q_valid) begin
          tri_r <= q_data;
          k     <= '0;
          vi    <= 1'b0;
        end
      end
      ttf_pkg::B_MUL: begin
        prod <= mul_w;
      end
      ttf_pkg::B_ACC: begin
        if (!k[0]) begin
          acc <= prod_x;
        end else begin
          res[ttf_pkg::RESW'(k >> 1)] <= diff;
        end
        k <= k + 1'b1;
        if (last_step) begin
          // The determinant was written on the second step.
          t_hold     <= '0;
          b_hold     <= '0;
          degen_hold <= det_zero;
        end
      end
      ttf_pkg::B_NWAIT: begin
        if (n_done) begin
          if (!vi) begin
            t_hold <= n_q;
            ok_t   <= !n_zero;
            vi     <= 1'b1;
          end else begin
            b_hold     <= n_q;
            degen_hold <= !(ok_t && !n_zero);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame.tangent_x   <= t_hold[0];
      frame.tangent_y   <= t_hold[1];
      frame.tangent_z   <= t_hold[2];
      frame.bitangent_x <= b_hold[0];
      frame.bitangent_y <= b_hold[1];
      frame.bitangent_z <= b_hold[2];
      frame.degenerate  <= degen_hold;
    end
  end

  assign frame.valid = fval;

endmodule

FILE: src/triangle_tangent_frame.sv
// Top level of the triangle tangent and bitangent unit.
// A vertex is taken each cycle while the triangle queue has room; the third vertex of a
// triangle enters a two-entry queue that feeds the arithmetic back end.
// From the third vertex transfer to an offered frame the back end pops the triangle, runs the
// products on the shared multiplier, normalizes each vector (alignment, square root, three
// divisions) and loads the output; a zero determinant skips the normalizing. The back end
// takes a new triangle only once its frame is loaded. Reset is synchronous, active high.
`timescale 1ns / 1ps
module triangle_tangent_frame (
  input  logic        clk,
  input  logic        rst,
  ttf_vtx_if.sink     vtx,
  ttf_frame_if.source frame
);

  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  ttf_pkg::tri_t push_data;
  ttf_pkg::tri_t pop_data;

  ttf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .vtx    (vtx),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  ttf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (pop_data)
  );

  ttf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .frame   (frame)
  );

endmodule

FILE: src/ttf_checker.sv
// Port-level checks on the tangent frame output, bound to the top level.
`timescale 1ns / 1ps
module ttf_checker (
  input logic           clk,
  input logic           rst,
  input logic           valid,
  input logic           ready,
  input ttf_pkg::unit_t tangent_x,
  input ttf_pkg::unit_t tangent_y,
  input ttf_pkg::unit_t tangent_z,
  input ttf_pkg::unit_t bitangent_x,
  input logic           degenerate
);

  // A frame that is offered stays offered until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("frame valid dropped before transfer");

  // A non-degenerate frame always has a nonzero tangent.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid && !degenerate |->
      (tangent_x != '0 || tangent_y != '0 || tangent_z != '0))
    else $error("non-degenerate frame with zero tangent");

  // The bitangent x component never leaves the range of one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($signed(bitangent_x) >= -16'sd16384 &&
               $signed(bitangent_x) <= 16'sd16384))
    else $error("bitangent component out of range");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("frame valid after reset");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (frame.valid),
  .ready       (frame.ready),
  .tangent_x   (frame.tangent_x),
  .tangent_y   (frame.tangent_y),
  .tangent_z   (frame.tangent_z),
  .bitangent_x (frame.bitangent_x),
  .degenerate  (frame.degenerate)
);

FILE: dv/ttf_frame_checker.sv
// Checker that predicts tangent frames from accepted vertices and compares the block's results.
`timescale 1ns / 1ps
module ttf_frame_checker (
  input  logic               clk,
  input  logic               rst,
  ttf_vtx_if.monitor         vtx,
  ttf_frame_if.monitor       frame,
  output int                 fails,
  output int                 pending,
  output int                 frames_seen,
  output int                 degen_seen
);

  typedef struct packed {
    ttf_pkg::unit_t tx;
    ttf_pkg::unit_t ty;
    ttf_pkg::unit_t tz;
    ttf_pkg::unit_t bx;
    ttf_pkg::unit_t by;
    ttf_pkg::unit_t bz;
    logic           degen;
  } frame_t;

  typedef logic signed [127:0] wide_t;

  frame_t frames_due[$];
  ttf_pkg::coord_t held_pos[2][3];
  ttf_pkg::coord_t held_uv[2][2];
  logic [1:0] held_cnt;

  assign pending = frames_due.size();

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Returns {nonzero, x, y, z}; components are Q2.14 with rounding half away from zero.
  function automatic logic [48:0] unit_vector(input wide_t c0, input wide_t c1, input wide_t c2);
    wide_t      mag[3];
    logic       neg[3];
    logic [63:0] m[3];
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] q;
    logic [15:0] o[3];
    int          len;
    mag[0] = c0;
    mag[1] = c1;
    mag[2] = c2;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = mag[i][127];
      if (neg[i]) mag[i] = -mag[i];
      for (int k = 0; k < 128; k++) if (mag[i][k] && k + 1 > len) len = k + 1;
    end
    if (len == 0) return 49'd0;
    for (int i = 0; i < 3; i++) begin
      if (len > 31) m[i] = 64'(mag[i] >> (len - 31));
      else m[i] = 64'(mag[i] << (31 - len));
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << ttf_pkg::OF) + (r >> 1)) / r;
      o[i] = neg[i] ? 16'(-q) : 16'(q);
    end
    return {1'b1, o[0], o[1], o[2]};
  endfunction

  function automatic frame_t tangent_frame(input ttf_pkg::coord_t p[3][3],
                                           input ttf_pkg::coord_t uv[3][2]);
    wide_t e1[3];
    wide_t e2[3];
    wide_t t[3];
    wide_t b[3];
    wide_t du1, dv1, du2, dv2, det;
    logic [48:0] ut, ub;
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      e1[i] = wide_t'(p[1][i]) - wide_t'(p[0][i]);
      e2[i] = wide_t'(p[2][i]) - wide_t'(p[0][i]);
    end
    du1 = wide_t'(uv[1][0]) - wide_t'(uv[0][0]);
    dv1 = wide_t'(uv[1][1]) - wide_t'(uv[0][1]);
    du2 = wide_t'(uv[2][0]) - wide_t'(uv[0][0]);
    dv2 = wide_t'(uv[2][1]) - wide_t'(uv[0][1]);
    det = du1 * dv2 - du2 * dv1;
    f = '0;
    if (det == 0) begin
      f.degen = 1'b1;
      return f;
    end
    for (int i = 0; i < 3; i++) begin
      t[i] = dv2 * e1[i] - dv1 * e2[i];
      b[i] = du1 * e2[i] - du2 * e1[i];
      // Only the sign of the reciprocal determinant survives normalization.
      if (det < 0) begin
        t[i] = -t[i];
        b[i] = -b[i];
      end
    end
    ut = unit_vector(t[0], t[1], t[2]);
    ub = unit_vector(b[0], b[1], b[2]);
    f.tx = ut[47:32];
    f.ty = ut[31:16];
    f.tz = ut[15:0];
    f.bx = ub[47:32];
    f.by = ub[31:16];
    f.bz = ub[15:0];
    f.degen = !(ut[48] && ub[48]);
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on frame %0d: %s got %h, expected %h", frames_seen, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    ttf_pkg::coord_t p[3][3];
    ttf_pkg::coord_t uv[3][2];
    frame_t want;
    if (rst) begin
      held_cnt <= 2'd0;
      frames_due.delete();
      fails = 0;
      frames_seen = 0;
      degen_seen = 0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        if (held_cnt < 2'd2) begin
          held_pos[held_cnt] <= '{vtx.pos_x, vtx.pos_y, vtx.pos_z};
          held_uv[held_cnt]  <= '{vtx.tex_u, vtx.tex_v};
          held_cnt <= held_cnt + 2'd1;
        end else begin
          for (int k = 0; k < 2; k++) begin
            p[k]  = held_pos[k];
            uv[k] = held_uv[k];
          end
          p[2]  = '{vtx.pos_x, vtx.pos_y, vtx.pos_z};
          uv[2] = '{vtx.tex_u, vtx.tex_v};
          frames_due = {frames_due, tangent_frame(p, uv)};
          held_cnt <= 2'd0;
        end
      end
      if (frame.valid && frame.ready) begin
        if (frames_due.size() == 0) begin
          $display("unexpected frame transfer %0d with nothing predicted", frames_seen);
          fails++;
        end else begin
          want = frames_due.pop_front();
          if (frame.tangent_x !== want.tx) report_mismatch("tangent_x", frame.tangent_x, want.tx);
          if (frame.tangent_y !== want.ty) report_mismatch("tangent_y", frame.tangent_y, want.ty);
          if (frame.tangent_z !== want.tz) report_mismatch("tangent_z", frame.tangent_z, want.tz);
          if (frame.bitangent_x !== want.bx)
            report_mismatch("bitangent_x", frame.bitangent_x, want.bx);
          if (frame.bitangent_y !== want.by)
            report_mismatch("bitangent_y", frame.bitangent_y, want.by);
          if (frame.bitangent_z !== want.bz)
            report_mismatch("bitangent_z", frame.bitangent_z, want.bz);
          if (frame.degenerate !== want.degen)
            report_mismatch("degenerate", 16'(frame.degenerate), 16'(want.degen));
          if (want.degen) degen_seen++;
        end
        frames_seen++;
      end
    end
  end
endmodule

FILE: dv/triangle_tangent_frame_tb.sv
// Testbench top: vertex stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps
module triangle_tangent_frame_tb;

  localparam int RANDOM_TRIANGLES = 377;
  localparam int CYCLE_LIMIT      = 2000000;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   fails, pending, frames_seen, degen_seen;
  int   burst_left;
  int   vertices_sent;
  bit   hold_req;

  ttf_vtx_if   vtx ();
  ttf_frame_if frame ();

  triangle_tangent_frame u_top (
    .clk   (clk),
    .rst   (rst),
    .vtx   (vtx),
    .frame (frame)
  );

  ttf_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .vtx         (vtx),
    .frame       (frame),
    .fails       (fails),
    .pending     (pending),
    .frames_seen (frames_seen),
    .degen_seen  (degen_seen)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: stall pattern is drawn at random from four modes; a hold request stalls it for a long run.
  initial begin
    int mode;
    int hold_cnt;
    frame.ready = 1'b0;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && hold_cnt == 0) hold_cnt = 3000;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_req = 1'b0;
        frame.ready <= 1'b0;
      end else begin
        case (mode)
          0: frame.ready <= 1'b1;
          1: frame.ready <= ($urandom_range(0, 1) == 1);
          2: frame.ready <= ($urandom_range(0, 9) == 0);
          default: frame.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offers one vertex; between bursts the valid line may drop for a random gap.
  task automatic send_vertex(input ttf_pkg::coord_t x, input ttf_pkg::coord_t y,
                             input ttf_pkg::coord_t z, input ttf_pkg::coord_t u,
                             input ttf_pkg::coord_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        vtx.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    vtx.valid <= 1'b1;
    vtx.pos_x <= x;
    vtx.pos_y <= y;
    vtx.pos_z <= z;
    vtx.tex_u <= u;
    vtx.tex_v <= v;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    vertices_sent++;
  endtask

  function automatic ttf_pkg::coord_t pick_coord(input int style);
    case (style)
      0: return ttf_pkg::coord_t'($urandom());
      1: return ttf_pkg::coord_t'($signed($urandom_range(0, 8)) - 4) <<< 16;
      2: return ttf_pkg::coord_t'($signed($urandom_range(0, 131072)) - 65536);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic send_random_triangle();
    int   style;
    int   kind;
    ttf_pkg::coord_t base[5];
    ttf_pkg::coord_t c[5];
    style = $urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3);
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 5; i++) base[i] = pick_coord(style);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) c[i] = pick_coord(style);
      // Repeated texture coordinates give a zero determinant; repeated positions a zero frame.
      if (kind == 0) begin
        c[3] = base[3];
        c[4] = base[4];
      end
      if (kind == 1) begin
        c[0] = base[0];
        c[1] = base[1];
        c[2] = base[2];
      end
      send_vertex(c[0], c[1], c[2], c[3], c[4]);
    end
  endtask

  initial begin
    localparam ttf_pkg::coord_t ONE = 32'sh0001_0000;
    localparam ttf_pkg::coord_t MAXC = 32'sh7fffffff;
    localparam ttf_pkg::coord_t MINC = 32'sh80000000;
    burst_left = 0;
    vertices_sent = 0;
    hold_req = 1'b0;
    vtx.valid = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.tex_u = '0;
    vtx.tex_v = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Plain unit triangle, then the same with the winding of the texture flipped.
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(ONE, 0, 0, ONE, 0);
    send_vertex(0, ONE, 0, 0, ONE);
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(ONE, 0, 0, 0, ONE);
    send_vertex(0, ONE, 0, ONE, 0);
    // Full-scale coordinates at both extremes.
    send_vertex(MINC, MINC, MINC, MINC, MINC);
    send_vertex(MAXC, MAXC, MAXC, MAXC, MINC);
    send_vertex(MINC, MAXC, 0, MINC, MAXC);
    // All texture coordinates equal: zero determinant.
    send_vertex(ONE, 0, 0, 5 * ONE, 3 * ONE);
    send_vertex(0, ONE, 0, 5 * ONE, 3 * ONE);
    send_vertex(0, 0, ONE, 5 * ONE, 3 * ONE);
    // All positions equal: both vectors have zero length.
    send_vertex(ONE, ONE, ONE, 0, 0);
    send_vertex(ONE, ONE, ONE, ONE, 0);
    send_vertex(ONE, ONE, ONE, 0, ONE);
    // First edge of zero length: only the tangent vanishes.
    send_vertex(7, -3, 2, 0, 0);
    send_vertex(7, -3, 2, ONE, 0);
    send_vertex(-ONE, 4, MAXC, 0, ONE);

    for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
      if (n == 40) hold_req = 1'b1;
      if (n == 200) begin
        @(negedge clk);
        vtx.valid <= 1'b0;
        wait (pending == 0);
      end
      send_random_triangle();
    end
    @(negedge clk);
    vtx.valid <= 1'b0;

    wait (pending == 0);
    repeat (400) @(posedge clk);
    $display("sent %0d vertices; %0d frames checked, %0d of them degenerate",
             vertices_sent, frames_seen, degen_seen);
    $display("run took %0d cycles with random gaps, stalls and one long hold-off", cycles);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
